>>> src/eacs_pkg.sv
// ----------------------------------------------------------------------------
// eacs_pkg: shared types and constants for the connection scan block
// Port payload types, the classified command that runs from the front end to
// the back end, and the fixed sizes of the command queue and epoch tags.
// ----------------------------------------------------------------------------
package eacs_pkg;

  // Field widths fixed by the interface
  localparam int STOP_FW = 10;
  localparam int TIME_FW = 20;
  localparam int ARR_FW  = 21;

  // Command queue depth and its pointer/count widths
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Epoch tag width: a stop is reached when its tag equals the current epoch
  localparam int EPOCH_W = 12;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_CONN  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [STOP_FW-1:0] source_stop;
    logic [TIME_FW-1:0] start_time;
    logic [STOP_FW-1:0] from_stop;
    logic [STOP_FW-1:0] to_stop;
    logic [TIME_FW-1:0] dep_time;
    logic [TIME_FW-1:0] duration;
    logic [STOP_FW-1:0] read_stop;
  } in_t;

  typedef struct packed {
    logic              improved;
    logic              reached;
    logic [ARR_FW-1:0] arrival_time;
  } out_t;

  // Classified command: port A reads a_stop, port B reads/writes b_stop
  typedef struct packed {
    action_t            op;
    logic [STOP_FW-1:0] a_stop;
    logic               a_ok;
    logic [STOP_FW-1:0] b_stop;
    logic               b_ok;
    logic [TIME_FW-1:0] t_lim;
    logic [ARR_FW-1:0]  et;
  } cmd_t;

endpackage

>>> src/earliest_arrival_connection_scan.sv
// ----------------------------------------------------------------------------
// earliest_arrival_connection_scan: earliest arrival connection scan engine
// Throughput: one transaction per cycle, set by the two-copy stop store,
// while neither a result-side stall nor a tag sweep holds the flow.
// Reset: a tag sweep over all stops clears the store; no input is taken then.
// The 4095th start after reset, and every 4094th start after that one, first
// stalls for another sweep (epoch wrap).
// ----------------------------------------------------------------------------
module earliest_arrival_connection_scan #(
  parameter int STOPS     = 1024,
  parameter int TIME_BITS = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  eacs_pkg::in_t  in_data,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output eacs_pkg::out_t out_data
);

  eacs_pkg::cmd_t push_cmd, q_data;
  logic push, pop, q_valid, q_full, clearing;

  // Accept and classify
  eacs_front #(.STOPS(STOPS), .TIME_BITS(TIME_BITS)) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Decoupling queue
  eacs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  // Store, relaxation and result
  eacs_back #(.STOPS(STOPS), .TIME_BITS(TIME_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> src/eacs_front.sv
// ----------------------------------------------------------------------------
// eacs_front: input acceptance and classification
// Masks the time fields, checks stop ranges, forms the connection arrival
// and maps each transaction onto the two memory ports of the back end.
// ----------------------------------------------------------------------------
module eacs_front #(
  parameter int STOPS     = 1024,
  parameter int TIME_BITS = 20
) (
  input  logic            in_valid,
  input  eacs_pkg::in_t   in_data,
  output logic            in_stall,
  input  logic            q_full,
  input  logic            clearing,
  output logic            push,
  output eacs_pkg::cmd_t  cmd
);

  localparam logic [32:0] TMASK = (33'd1 << TIME_BITS) - 33'd1;

  logic [eacs_pkg::TIME_FW-1:0] start_m, dep_m, dur_m;
  logic from_ok, to_ok, src_ok, rd_ok;

  // Stop range checks
  assign from_ok = 32'(in_data.from_stop)   < 32'(STOPS);
  assign to_ok   = 32'(in_data.to_stop)     < 32'(STOPS);
  assign src_ok  = 32'(in_data.source_stop) < 32'(STOPS);
  assign rd_ok   = 32'(in_data.read_stop)   < 32'(STOPS);

  // Times are taken in their low TIME_BITS bits
  assign start_m = in_data.start_time & TMASK[eacs_pkg::TIME_FW-1:0];
  assign dep_m   = in_data.dep_time   & TMASK[eacs_pkg::TIME_FW-1:0];
  assign dur_m   = in_data.duration   & TMASK[eacs_pkg::TIME_FW-1:0];

  // No acceptance while the queue is full or the tag store is being cleared
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  // Classification
  always_comb begin
    cmd.op     = eacs_pkg::action_t'(in_data.action);
    cmd.a_stop = in_data.from_stop;
    cmd.a_ok   = from_ok;
    cmd.b_stop = in_data.to_stop;
    cmd.b_ok   = to_ok;
    cmd.t_lim  = dep_m;
    cmd.et     = {1'b0, dep_m} + {1'b0, dur_m};
    case (cmd.op)
      eacs_pkg::ACT_START: begin
        cmd.b_stop = in_data.source_stop;
        cmd.b_ok   = src_ok;
        cmd.t_lim  = start_m;
      end
      eacs_pkg::ACT_CONN: begin
        cmd.b_stop = in_data.to_stop;
      end
      eacs_pkg::ACT_READ: begin
        cmd.b_stop = in_data.read_stop;
        cmd.b_ok   = rd_ok;
      end
      default: begin
        cmd.a_ok = 1'b0;
        cmd.b_ok = 1'b0;
      end
    endcase
  end

endmodule

>>> src/eacs_queue.sv
// ----------------------------------------------------------------------------
// eacs_queue: command queue between front end and back end
// Small register FIFO; lets the front keep accepting while the back stalls.
// ----------------------------------------------------------------------------
module eacs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  eacs_pkg::cmd_t push_data,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output eacs_pkg::cmd_t q_data
);

  eacs_pkg::cmd_t                slot_r [eacs_pkg::QDEPTH];
  logic [eacs_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [eacs_pkg::QCNT_W-1:0]   cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == eacs_pkg::QCNT_W'(eacs_pkg::QDEPTH));
  assign q_data  = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !push)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (!rst_n) !q_valid |-> !pop)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a write");

endmodule

>>> src/eacs_back.sv
// ----------------------------------------------------------------------------
// eacs_back: stop store, relaxation pipeline and result register
// Two copies of the stop store (epoch tag plus arrival) give two reads and a
// shared write per cycle; a one-entry forward covers the write in flight.
// ----------------------------------------------------------------------------
module eacs_back #(
  parameter int STOPS     = 1024,
  parameter int TIME_BITS = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  eacs_pkg::cmd_t q_data,
  output logic           pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output eacs_pkg::out_t out_data
);

  localparam int SW = (STOPS > 1) ? $clog2(STOPS) : 1;
  localparam int TB = (TIME_BITS < eacs_pkg::TIME_FW) ? TIME_BITS : eacs_pkg::TIME_FW;
  localparam int AW = TB + 1;
  localparam int EW = eacs_pkg::EPOCH_W;
  localparam int WW = EW + AW;
  localparam logic [SW-1:0] LAST = SW'(STOPS - 1);

  function automatic logic [SW-1:0] to_idx(input logic [eacs_pkg::STOP_FW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SW-1:0];
  endfunction

  logic [WW-1:0] mem_a [STOPS];
  logic [WW-1:0] mem_b [STOPS];

  logic [WW-1:0]   rd_a_r, rd_b_r, fwd_word_r;
  logic [SW-1:0]   fwd_idx_r, sweep_cnt_r;
  logic            fwd_valid_r, sweep_r, s1_valid_r, out_valid_r;
  logic [EW-1:0]   cur_r;
  eacs_pkg::cmd_t  s1_r;
  eacs_pkg::out_t  out_r, res;

  logic            adv, need_sweep, wr_en, take;
  logic [SW-1:0]   wr_idx, s1_idx_a, s1_idx_b;
  logic [WW-1:0]   wr_word, word_u, word_v;
  logic [AW-1:0]   arr_u, arr_v;
  logic            reach_u, reach_v;
  logic [20:0]     start_x;

  assign s1_idx_a = to_idx(s1_r.a_stop);
  assign s1_idx_b = to_idx(s1_r.b_stop);

  // Pipeline control: a wrapping start first sweeps the tag store
  assign need_sweep = s1_valid_r && !sweep_r && (s1_r.op == eacs_pkg::ACT_START) &&
                      (cur_r == '1);
  assign adv = !sweep_r && !need_sweep && (!s1_valid_r || !out_valid_r || !out_stall);
  assign pop = adv && q_valid;
  assign clearing  = sweep_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Forward the write made on the edge that loaded this stage
  assign word_u  = (fwd_valid_r && fwd_idx_r == s1_idx_a) ? fwd_word_r : rd_a_r;
  assign word_v  = (fwd_valid_r && fwd_idx_r == s1_idx_b) ? fwd_word_r : rd_b_r;
  assign arr_u   = word_u[AW-1:0];
  assign arr_v   = word_v[AW-1:0];
  assign reach_u = s1_r.a_ok && (word_u[WW-1:AW] == cur_r);
  assign reach_v = s1_r.b_ok && (word_v[WW-1:AW] == cur_r);
  assign start_x = {1'b0, s1_r.t_lim};

  // Relaxation decision and store write
  always_comb begin
    res     = '0;
    take    = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = s1_idx_b;
    wr_word = '0;
    if (sweep_r) begin
      wr_en  = 1'b1;
      wr_idx = sweep_cnt_r;
    end else begin
      case (s1_r.op)
        eacs_pkg::ACT_START: begin
          if (s1_r.b_ok) begin
            wr_en            = adv && s1_valid_r;
            wr_word          = {cur_r + 1'b1, start_x[AW-1:0]};
            res.reached      = 1'b1;
            res.arrival_time = start_x;
          end
        end
        eacs_pkg::ACT_CONN: begin
          take = reach_u && (21'(arr_u) <= {1'b0, s1_r.t_lim}) && s1_r.b_ok &&
                 (!reach_v || (21'(arr_v) > s1_r.et));
          if (take) begin
            wr_en            = adv && s1_valid_r;
            wr_word          = {cur_r, s1_r.et[AW-1:0]};
            res.improved     = 1'b1;
            res.reached      = 1'b1;
            res.arrival_time = s1_r.et;
          end
        end
        eacs_pkg::ACT_READ: begin
          if (reach_v) begin
            res.reached      = 1'b1;
            res.arrival_time = 21'(arr_v);
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  // Store copy A: read at the from-stop
  always_ff @(posedge clk) begin
    if (wr_en) mem_a[wr_idx] <= wr_word;
    if (adv)   rd_a_r <= mem_a[to_idx(q_data.a_stop)];
  end

  // Store copy B: read at the to-stop, source stop or read stop
  always_ff @(posedge clk) begin
    if (wr_en) mem_b[wr_idx] <= wr_word;
    if (adv)   rd_b_r <= mem_b[to_idx(q_data.b_stop)];
  end

  // Control state: stage valid, result valid, forward, epoch and sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      cur_r       <= EW'(1);
    end else begin
      if (need_sweep) begin
        sweep_r     <= 1'b1;
        sweep_cnt_r <= '0;
      end else if (sweep_r) begin
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == LAST) begin
          sweep_r <= 1'b0;
          cur_r   <= EW'(1);
        end
      end
      if (adv) begin
        s1_valid_r  <= q_valid;
        fwd_valid_r <= wr_en;
        if (s1_valid_r && s1_r.op == eacs_pkg::ACT_START) cur_r <= cur_r + 1'b1;
      end
      if (adv && s1_valid_r) out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= q_data;
      fwd_idx_r <= wr_idx;
      fwd_word_r <= wr_word;
    end
    if (adv && s1_valid_r) out_r <= res;
  end

  assert property (@(posedge clk) disable iff (!rst_n) sweep_r |-> !pop)
    else $error("command popped during tag sweep");
  assert property (@(posedge clk) disable iff (!rst_n) cur_r != '0)
    else $error("current epoch matches swept tags");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |-> (!out_r.improved || out_r.reached))
    else $error("improved result not marked reached");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (adv && s1_valid_r && take) |=> fwd_valid_r)
    else $error("taken connection left no forward entry");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for earliest_arrival_connection_scan
// Drives start, connection, read and unused-action transactions, with random
// gaps on the input and random stalls on the result side. A scan predictor
// keeps its own arrival times and reached flags for every stop and checks
// each result field by field, in order. Most random traffic is built as
// queries: a start, then connections in departure order over a small pool
// of stops, with reads mixed in. The rest is noise and out-of-order items.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_STOPS   = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SCAN_ITEMS  = 1650;
  localparam int NOISE_ITEMS = 250;
  localparam int MAX_PRINTS  = 40;
  localparam int STOP_W      = eacs_pkg::STOP_FW;
  localparam int TIME_W      = eacs_pkg::TIME_FW;
  localparam int ARR_W       = eacs_pkg::ARR_FW;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  eacs_pkg::in_t  in_data   = '0;
  logic           in_stall;
  logic           out_valid;
  logic           out_stall = 1'b0;
  eacs_pkg::out_t out_data;

  // Predictor state: arrival time per stop and the current query's reached set
  logic [ARR_W-1:0]     stop_arrival [NUM_STOPS];
  logic [NUM_STOPS-1:0] stop_reached = '0;

  eacs_pkg::out_t pending_answers [$];

  int   err_count      = 0;
  int   cycle_count    = 0;
  int   accepted_count = 0;
  int   checked_count  = 0;
  int   start_count    = 0;
  int   improved_count = 0;
  int   stall_left     = 0;
  bit   quiet_run      = 1'b0;

  earliest_arrival_connection_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Scan predictor: applies one transaction and returns the answer it causes
  function automatic eacs_pkg::out_t scan_step(eacs_pkg::in_t item);
    eacs_pkg::out_t   ans;
    logic [ARR_W-1:0] arr_at;
    ans = '0;
    case (eacs_pkg::action_t'(item.action))
      eacs_pkg::ACT_START: begin
        start_count++;
        stop_reached = '0;
        if (int'(item.source_stop) < NUM_STOPS) begin
          stop_reached[item.source_stop] = 1'b1;
          stop_arrival[item.source_stop] = ARR_W'(item.start_time);
          ans.reached      = 1'b1;
          ans.arrival_time = ARR_W'(item.start_time);
        end
      end
      eacs_pkg::ACT_CONN: begin
        arr_at = ARR_W'(item.dep_time) + ARR_W'(item.duration);
        if (int'(item.from_stop) < NUM_STOPS && int'(item.to_stop) < NUM_STOPS &&
            stop_reached[item.from_stop] &&
            stop_arrival[item.from_stop] <= ARR_W'(item.dep_time) &&
            (!stop_reached[item.to_stop] || stop_arrival[item.to_stop] > arr_at)) begin
          stop_reached[item.to_stop] = 1'b1;
          stop_arrival[item.to_stop] = arr_at;
          ans.improved     = 1'b1;
          ans.reached      = 1'b1;
          ans.arrival_time = arr_at;
          improved_count++;
        end
      end
      eacs_pkg::ACT_READ: begin
        if (int'(item.read_stop) < NUM_STOPS && stop_reached[item.read_stop]) begin
          ans.reached      = 1'b1;
          ans.arrival_time = stop_arrival[item.read_stop];
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Item builders: fields the action ignores carry random junk
  function automatic eacs_pkg::in_t rand_item();
    eacs_pkg::in_t item;
    item.action      = 2'($urandom_range(0, 3));
    item.source_stop = STOP_W'($urandom);
    item.start_time  = TIME_W'($urandom);
    item.from_stop   = STOP_W'($urandom);
    item.to_stop     = STOP_W'($urandom);
    item.dep_time    = TIME_W'($urandom);
    item.duration    = TIME_W'($urandom);
    item.read_stop   = STOP_W'($urandom);
    return item;
  endfunction

  function automatic eacs_pkg::in_t make_start(logic [STOP_W-1:0] src,
                                               logic [TIME_W-1:0] t0);
    eacs_pkg::in_t item;
    item             = rand_item();
    item.action      = eacs_pkg::ACT_START;
    item.source_stop = src;
    item.start_time  = t0;
    return item;
  endfunction

  function automatic eacs_pkg::in_t make_conn(logic [STOP_W-1:0] u, logic [STOP_W-1:0] v,
                                              logic [TIME_W-1:0] dep,
                                              logic [TIME_W-1:0] dur);
    eacs_pkg::in_t item;
    item           = rand_item();
    item.action    = eacs_pkg::ACT_CONN;
    item.from_stop = u;
    item.to_stop   = v;
    item.dep_time  = dep;
    item.duration  = dur;
    return item;
  endfunction

  function automatic eacs_pkg::in_t make_read(logic [STOP_W-1:0] s);
    eacs_pkg::in_t item;
    item           = rand_item();
    item.action    = eacs_pkg::ACT_READ;
    item.read_stop = s;
    return item;
  endfunction

  function automatic eacs_pkg::in_t make_idle_op();
    eacs_pkg::in_t item;
    item        = rand_item();
    item.action = eacs_pkg::ACT_NONE;
    return item;
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return TIME_W'($urandom_range(0, 40));
    if (r < 95) return TIME_W'($urandom_range(0, 4000));
    return TIME_W'($urandom);
  endfunction

  // Send one transaction; valid stays high from one item into the next unless a gap is picked
  task automatic send_item(input eacs_pkg::in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    accepted_count++;
    pending_answers.push_back(scan_step(item));
  endtask

  // Hold off the input until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    err_count++;
  endtask

  // Result side: compare against the oldest expectation, then pick the stall
  always @(posedge clk) begin : answer_check
    eacs_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data), 32'd0);
      end else begin
        want = pending_answers.pop_front();
        checked_count++;
        if (out_data.improved !== want.improved)
          report_mismatch("improved", 32'(out_data.improved), 32'(want.improved));
        if (out_data.reached !== want.reached)
          report_mismatch("reached", 32'(out_data.reached), 32'(want.reached));
        if (out_data.arrival_time !== want.arrival_time)
          report_mismatch("arrival_time", 32'(out_data.arrival_time),
                          32'(want.arrival_time));
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet_run && $urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall  <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end
  end

  // Field extremes, tie and boundary rules, stale stops after a new start
  task automatic test_corner_cases();
    send_item(make_start(10'd0, 20'd0));
    send_item(make_read(10'd0));
    send_item(make_conn(10'd0, 10'h3FF, 20'd0, TIME_MAX));
    send_item(make_read(10'h3FF));
    send_item(make_conn(10'd0, 10'h3FF, 20'd0, 20'd5));
    // equal arrival is not an improvement
    send_item(make_conn(10'd0, 10'h3FF, 20'd0, 20'd5));
    send_item(make_conn(10'd0, 10'h3FF, 20'd1, 20'd4));
    // departure from an unreached stop
    send_item(make_conn(10'd512, 10'd1, 20'd0, 20'd1));
    // from-stop reached only after the departure
    send_item(make_conn(10'h3FF, 10'd1, 20'd4, 20'd1));
    // departure exactly at the from-stop's arrival
    send_item(make_conn(10'h3FF, 10'd1, 20'd5, 20'd0));
    send_item(make_conn(10'd1, 10'd1, 20'd5, 20'd0));
    send_item(make_idle_op());
    send_item(make_read(10'd1));
    send_item(make_start(10'h3FF, TIME_MAX));
    send_item(make_read(10'd0));
    send_item(make_read(10'd1));
    // largest possible arrival
    send_item(make_conn(10'h3FF, 10'd0, TIME_MAX, TIME_MAX));
    send_item(make_read(10'd0));
    send_item(make_start(10'h2AA, 20'h55555));
    send_item(make_read(10'h155));
    send_item(make_start(10'h155, 20'hAAAAA));
    send_item(make_conn(10'h155, 10'h2AA, 20'hAAAAA, 20'h55555));
    send_item(make_read(10'h2AA));
    send_item(make_read(10'h3FF));
  endtask

  // One query over a small pool of stops, connections mostly in departure order
  task automatic run_one_query(input int n_items);
    logic [STOP_W-1:0] pool [24];
    int                pool_n;
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] step;
    logic [STOP_W-1:0] u;
    int                r;
    pool_n = $urandom_range(2, 24);
    for (int k = 0; k < pool_n; k++) pool[k] = STOP_W'($urandom);
    case ($urandom_range(0, 3))
      0:       clock_now = '0;
      1:       clock_now = TIME_MAX - TIME_W'($urandom_range(0, 3000));
      default: clock_now = TIME_W'($urandom);
    endcase
    send_item(make_start(pool[0], clock_now));
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        u = pool[$urandom_range(0, pool_n - 1)];
        if (r < 55) begin
          repeat (4) if (!stop_reached[u]) u = pool[$urandom_range(0, pool_n - 1)];
        end
        step = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom_range(1, 30));
        clock_now = (TIME_MAX - clock_now < step) ? TIME_MAX : clock_now + step;
        send_item(make_conn(u, pool[$urandom_range(0, pool_n - 1)], clock_now,
                            pick_duration()));
      end else if (r < 88) begin
        if ($urandom_range(0, 4) == 0) send_item(make_read(STOP_W'($urandom)));
        else send_item(make_read(pool[$urandom_range(0, pool_n - 1)]));
      end else if (r < 93) begin
        send_item(make_idle_op());
      end else if (r < 97) begin
        // out of departure order
        step = TIME_W'($urandom_range(1, 200));
        send_item(make_conn(pool[$urandom_range(0, pool_n - 1)],
                            pool[$urandom_range(0, pool_n - 1)],
                            (clock_now < step) ? '0 : clock_now - step, pick_duration()));
      end else begin
        send_item(make_conn(STOP_W'($urandom), STOP_W'($urandom),
                            TIME_W'($urandom), TIME_W'($urandom)));
      end
    end
  endtask

  // Back-to-back burst, then one with gaps; after each, input holds off till results are in
  task automatic test_drain_pause();
    quiet_run = 1'b1;
    run_one_query(20);
    wait_drain();
    quiet_run = 1'b0;
    run_one_query(10);
    wait_drain();
  endtask

  task automatic test_query_scans();
    int sent;
    int n_items;
    sent = 0;
    while (sent < SCAN_ITEMS) begin
      quiet_run = ($urandom_range(0, 5) == 0);
      n_items = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(4, 40);
      run_one_query(n_items);
      sent += n_items + 1;
      if ($urandom_range(0, 7) == 0) wait_drain();
    end
    quiet_run = 1'b0;
  endtask

  // Fully random transactions, all field values allowed
  task automatic test_random_noise();
    repeat (NOISE_ITEMS) send_item(rand_item());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_drain_pause();
    test_query_scans();
    test_random_noise();
    wait_drain();
    repeat (8) @(posedge clk);
    $display("covered %0d transactions in %0d queries, %0d results checked",
             accepted_count, start_count, checked_count);
    $display("%0d connections improved an arrival, %0d mismatches",
             improved_count, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/eacs_pkg.sv
src/eacs_front.sv
src/eacs_queue.sv
src/eacs_back.sv
src/earliest_arrival_connection_scan.sv
tb/tb.sv
